// ===== src/rcq_pkg.sv =====
package rcq_pkg;

    // Field widths of the stream items and of the configuration registers.
    localparam int KEY_W       = 32;
    localparam int FRAG_W      = 16;
    localparam int OFFS_W      = 16;
    localparam int SIZE_W      = 17;
    localparam int SPAN_W      = 5;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;
    localparam int DCAP_W      = 17;
    localparam int ICAP_W      = 11;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 56;

    // Defaults for the top-level parameters.
    localparam int INDEX_DEPTH_DEF    = 1024;
    localparam int DATA_BYTES_MAX_DEF = 65536;

    // Reset values of the configuration registers.
    localparam logic [DCAP_W-1:0] DCAP_RESET = 17'd32768;
    localparam logic [ICAP_W-1:0] ICAP_RESET = 11'd1024;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DRAIN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DATA_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INDEX_FULL = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY      = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DATA_CAP  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INDEX_CAP = 1'd1;

    // Broadcast from the controller to every cell of the key chain.
    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
    } ins_t;

endpackage

// ===== src/rcq_cell.sv =====
module rcq_cell
    import rcq_pkg::*;
#(
    parameter int CNT_W = 11,
    parameter int POS   = 0
)
(
    input  logic             clk,
    input  ins_t             ins,
    input  logic [CNT_W-1:0] count,
    input  logic [KEY_W-1:0] prev_key,
    input  logic             prev_gt,
    output logic [KEY_W-1:0] key,
    output logic             gt
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             occupied;
    logic             at_end;

    // A cell holds a live key when its position is below the fill count.
    assign occupied = CNT_W'(POS) < count;
    assign at_end   = CNT_W'(POS) == count;
    assign gt       = occupied && (key_reg > ins.key);
    assign key      = key_reg;

    // Every cell whose key is larger than the new one moves up by one place;
    // the lowest such cell (or the first free cell) takes the new key.
    always_comb
    begin
        key_next = key_reg;
        if (ins.en && (gt || at_end))
        begin
            key_next = prev_gt ? prev_key : ins.key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== src/rcq_key_chain.sv =====
module rcq_key_chain
    import rcq_pkg::*;
#(
    parameter int INDEX_DEPTH = INDEX_DEPTH_DEF,
    parameter int CNT_W       = $clog2(INDEX_DEPTH + 1),
    parameter int IDX_W       = $clog2(INDEX_DEPTH)
)
(
    input  logic             clk,
    input  ins_t             ins,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    localparam int GRP_W  = (IDX_W < 5) ? IDX_W : 5;
    localparam int GRP    = 1 << GRP_W;
    localparam int HI_W   = (IDX_W - GRP_W < 1) ? 1 : IDX_W - GRP_W;
    localparam int NGRP   = 1 << HI_W;

    logic [KEY_W-1:0] keys    [INDEX_DEPTH];
    logic             gts     [INDEX_DEPTH];
    logic [KEY_W-1:0] grp_reg [NGRP];
    logic [KEY_W-1:0] grp_next[NGRP];
    logic [HI_W-1:0]  hi_reg;
    logic [HI_W-1:0]  hi_next;
    logic [KEY_W-1:0] rd_data_reg;
    logic [KEY_W-1:0] rd_data_next;
    logic [GRP_W-1:0] rd_lo;
    logic [GRP_W+HI_W-1:0] addr_ext;

    genvar i;
    generate
        for (i = 0; i < INDEX_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                rcq_cell #(.CNT_W(CNT_W), .POS(i)) u_cell (
                    .clk      (clk),
                    .ins      (ins),
                    .count    (count),
                    .prev_key ({KEY_W{1'b0}}),
                    .prev_gt  (1'b0),
                    .key      (keys[i]),
                    .gt       (gts[i])
                );
            end
            else
            begin : g_rest
                rcq_cell #(.CNT_W(CNT_W), .POS(i)) u_cell (
                    .clk      (clk),
                    .ins      (ins),
                    .count    (count),
                    .prev_key (keys[i-1]),
                    .prev_gt  (gts[i-1]),
                    .key      (keys[i]),
                    .gt       (gts[i])
                );
            end
        end
    endgenerate

    // Two-step read: pick one key per group of cells, then pick the group.
    assign addr_ext = (GRP_W + HI_W)'(rd_addr);
    assign rd_lo    = addr_ext[GRP_W-1:0];
    assign hi_next  = addr_ext[GRP_W +: HI_W];

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                if ((g * GRP + j < INDEX_DEPTH) && (rd_lo == GRP_W'(j)))
                begin
                    grp_next[g] = keys[g * GRP + j];
                end
            end
        end
    end

    assign rd_data_next = grp_reg[hi_reg];
    assign rd_data      = rd_data_reg;

    always_ff @(posedge clk)
    begin
        grp_reg     <= grp_next;
        hi_reg      <= hi_next;
        rd_data_reg <= rd_data_next;
    end

endmodule

// ===== src/render_command_queue_sorter_core.sv =====
// Render command queue with a sorted key index. A submit item reserves
// cmd_size bytes from a bump cursor (advanced by the size rounded up to four)
// and appends one 32-bit key per covered fragment, {fragment, offset}, into a
// chain of cells that keeps the keys in ascending order; a drain item returns
// the next key in that order and reports empty once all are gone; a clear item
// empties the data cursor, the key count and the drain pointer. Every input
// item gives exactly one result item. A submit passes the state CHECK and
// then INSERT once per key, because the cell chain inserts one key per cycle
// (span 0 counts as one); a submit rejected for data or index space stops
// after its check step. A drain passes the states READ1 and READ2, set by the
// two-step registered read out of the cell chain, while a drain on an empty
// queue and clear and unused requests go straight to the result step. The
// next item can be taken in the cycle after the result register is loaded. A
// new item is accepted only once the previous one has reached the output
// register, while that result may still be waiting for the consumer; a
// finished item waits in its last step until the output register is free.
// Configuration writes are to be made only while the block is idle; the block
// itself does not enforce this. Writing a changed capacity empties its part
// of the queue.
module render_command_queue_sorter_core
    import rcq_pkg::*;
#(
    parameter int INDEX_DEPTH    = INDEX_DEPTH_DEF,
    parameter int DATA_BYTES_MAX = DATA_BYTES_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, from bit 0 up: cmd_size[16:0], start_fragment[32:17],
    // fragment_span[37:33], zero fill[39:38].
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[1:0].
    input  logic [REQ_W-1:0]      s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, from bit 0 up: status[1:0], data_offset[17:2],
    // entry_fragment[33:18], entry_offset[49:34], zero fill[55:50].
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tlast: last_entry.
    output logic                  m_tlast
);

    localparam int CNT_W   = $clog2(INDEX_DEPTH + 1);
    localparam int IDX_W   = $clog2(INDEX_DEPTH);
    localparam int DCUR_W  = $clog2(DATA_BYTES_MAX + 1);
    localparam int AW      = DCUR_W + 1;
    localparam int ICMP_W  = ((CNT_W > ICAP_W) ? CNT_W : ICAP_W) + 1;
    localparam logic [DCAP_W-1:0] DMAX = DCAP_W'(DATA_BYTES_MAX);
    localparam logic [ICMP_W-1:0] IMAX = ICMP_W'(INDEX_DEPTH);

    // One-hot controller states.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_INSERT = 6'b000100,
        ST_READ1  = 6'b001000,
        ST_READ2  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;

    logic [DCAP_W-1:0]   dcap_reg, dcap_next;
    logic [ICAP_W-1:0]   icap_reg, icap_next;
    logic [DCUR_W-1:0]   cursor_reg, cursor_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    dptr_reg, dptr_next;

    // Latched request and per-item work registers.
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [FRAG_W-1:0]   frag_reg, frag_next;
    logic [SPAN_W-1:0]   span_reg, span_next;

    // Result being built.
    logic [STAT_W-1:0]   rstat_reg, rstat_next;
    logic [OFFS_W-1:0]   roffs_reg, roffs_next;
    logic [FRAG_W-1:0]   rfrag_reg, rfrag_next;
    logic [OFFS_W-1:0]   reoff_reg, reoff_next;
    logic                rlast_reg, rlast_next;

    // Output register.
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    logic                in_acc;
    logic                out_free;
    logic [REQ_W-1:0]    in_req;

    // Submit check arithmetic.
    logic [DCAP_W-1:0]   dcap_eff;
    logic [AW-1:0]       cap_a;
    logic [AW-1:0]       cur_a;
    logic [AW-1:0]       size_a;
    logic [AW-1:0]       free_a;
    logic [AW-1:0]       round_a;
    logic [AW-1:0]       sum_a;
    logic [SPAN_W-1:0]   span_eff;
    logic [ICMP_W-1:0]   icap_eff;
    logic [ICMP_W-1:0]   need_cnt;

    ins_t                ins;
    logic [KEY_W-1:0]    rd_data;
    logic [IDX_W-1:0]    rd_addr;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_req   = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign rd_addr  = dptr_reg[IDX_W-1:0];

    assign ins.en  = (state_reg == ST_INSERT);
    assign ins.key = {frag_reg, roffs_reg};

    rcq_key_chain #(
        .INDEX_DEPTH (INDEX_DEPTH),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_chain (
        .clk     (clk),
        .ins     (ins),
        .count   (count_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Capacities above the design limits act as the limits.
    assign dcap_eff = (dcap_reg > DMAX) ? DMAX : dcap_reg;
    assign icap_eff = (ICMP_W'(icap_reg) > IMAX) ? IMAX : ICMP_W'(icap_reg);

    assign cap_a    = AW'(dcap_eff);
    assign cur_a    = AW'(cursor_reg);
    assign size_a   = AW'(size_reg);
    assign free_a   = (cap_a > cur_a) ? (cap_a - cur_a) : '0;
    assign round_a  = (size_a + AW'(3)) & ~AW'(3);
    assign sum_a    = cur_a + round_a;
    assign span_eff = (span_reg == '0) ? SPAN_W'(1) : span_reg;
    assign need_cnt = ICMP_W'(count_reg) + ICMP_W'(span_eff);

    always_comb
    begin
        state_next    = state_reg;
        dcap_next     = dcap_reg;
        icap_next     = icap_reg;
        cursor_next   = cursor_reg;
        count_next    = count_reg;
        dptr_next     = dptr_reg;
        size_next     = size_reg;
        frag_next     = frag_reg;
        span_next     = span_reg;
        rstat_next    = rstat_reg;
        roffs_next    = roffs_reg;
        rfrag_next    = rfrag_reg;
        reoff_next    = reoff_reg;
        rlast_next    = rlast_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // A changed capacity empties the part of the queue it governs.
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DATA_CAP:
                begin
                    if (cfg_data[DCAP_W-1:0] != dcap_reg)
                    begin
                        dcap_next   = cfg_data[DCAP_W-1:0];
                        cursor_next = '0;
                    end
                end
                REG_INDEX_CAP:
                begin
                    if (cfg_data[ICAP_W-1:0] != icap_reg)
                    begin
                        icap_next  = cfg_data[ICAP_W-1:0];
                        count_next = '0;
                        dptr_next  = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    size_next  = s_tdata[SIZE_W-1:0];
                    frag_next  = s_tdata[SIZE_W +: FRAG_W];
                    span_next  = s_tdata[SIZE_W + FRAG_W +: SPAN_W];
                    rstat_next = STAT_OK;
                    roffs_next = '0;
                    rfrag_next = '0;
                    reoff_next = '0;
                    rlast_next = 1'b0;
                    unique case (in_req)
                        REQ_SUBMIT:
                        begin
                            state_next = ST_CHECK;
                        end
                        REQ_DRAIN:
                        begin
                            // The read address is the drain pointer itself.
                            if (dptr_reg < count_reg)
                            begin
                                state_next = ST_READ1;
                            end
                            else
                            begin
                                rstat_next = STAT_EMPTY;
                                state_next = ST_DONE;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                            dptr_next   = '0;
                            state_next  = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_CHECK:
            begin
                if (size_a > free_a)
                begin
                    rstat_next = STAT_DATA_FULL;
                    state_next = ST_DONE;
                end
                else
                begin
                    roffs_next = OFFS_W'(cursor_reg);
                    // When the rounded size does not fit, the cursor stays.
                    if (sum_a <= cap_a)
                    begin
                        cursor_next = sum_a[DCUR_W-1:0];
                    end
                    if (need_cnt > icap_eff)
                    begin
                        rstat_next = STAT_INDEX_FULL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        span_next  = span_eff;
                        state_next = ST_INSERT;
                    end
                end
            end

            ST_INSERT:
            begin
                // The chain takes {frag_reg, roffs_reg} in this cycle.
                count_next = count_reg + CNT_W'(1);
                frag_next  = frag_reg + FRAG_W'(1);
                span_next  = span_reg - SPAN_W'(1);
                if (span_reg == SPAN_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_READ1:
            begin
                state_next = ST_READ2;
            end

            ST_READ2:
            begin
                rfrag_next = rd_data[KEY_W-1 -: FRAG_W];
                reoff_next = rd_data[OFFS_W-1:0];
                rlast_next = ((dptr_reg + CNT_W'(1)) == count_reg);
                dptr_next  = dptr_reg + CNT_W'(1);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({reoff_reg, rfrag_reg, roffs_reg,
                                                rstat_reg});
                    m_tlast_next  = rlast_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            dcap_reg     <= DCAP_RESET;
            icap_reg     <= ICAP_RESET;
            cursor_reg   <= '0;
            count_reg    <= '0;
            dptr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dcap_reg     <= dcap_next;
            icap_reg     <= icap_next;
            cursor_reg   <= cursor_next;
            count_reg    <= count_next;
            dptr_reg     <= dptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg    <= size_next;
        frag_reg    <= frag_next;
        span_reg    <= span_next;
        rstat_reg   <= rstat_next;
        roffs_reg   <= roffs_next;
        rfrag_reg   <= rfrag_next;
        reoff_reg   <= reoff_next;
        rlast_reg   <= rlast_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule
